// ----- design/etsc_pkg.sv -----
// etsc_pkg: shared token types and constants for the expression token scanner
`timescale 1ns / 1ps

package etsc_pkg;

  // widths of the result fields
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned KIND_W  = 4;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // token queue between scanner and output stage
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // packed stream data: kind, offset, length, zero padding to whole bytes
  localparam int unsigned TDATA_BITS = KIND_W + OUT_W + OUT_W;
  localparam int unsigned TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;

  // token kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ERR    = 4'd0,
    KIND_EOF    = 4'd1,
    KIND_IDENT  = 4'd2,
    KIND_NUMBER = 4'd3,
    KIND_PLUS   = 4'd4,
    KIND_MINUS  = 4'd5,
    KIND_STAR   = 4'd6,
    KIND_SLASH  = 4'd7,
    KIND_PCT    = 4'd8,
    KIND_CARET  = 4'd9,
    KIND_EQ     = 4'd10,
    KIND_LPAREN = 4'd11,
    KIND_RPAREN = 4'd12,
    KIND_COMMA  = 4'd13
  } kind_t;

  // character codes
  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CH_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_PCT    = 8'h25;
  localparam logic [CH_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CH_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_0      = 8'h30;
  localparam logic [CH_W-1:0] CH_9      = 8'h39;
  localparam logic [CH_W-1:0] CH_LA     = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ     = 8'h7A;
  localparam logic [CH_W-1:0] CH_UA     = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ     = 8'h5A;

  // one token record
  typedef struct packed {
    kind_t            kind;
    logic [OUT_W-1:0] offset;
    logic [OUT_W-1:0] length;
    logic             last;
  } tok_t;

  // tokens produced by one accepted byte
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } push_t;

endpackage

// ----- design/expression_token_scanner.sv -----
// expression_token_scanner: streaming lexer for calculator expression text
//
//   channel | dir | tdata fields (low bit up)                   | tlast
//   in_     | in  | ch[7:0]                                     | -
//   out_    | out | token_kind[3:0] token_offset[19:4]          | last_of_run
//           |     | token_length[35:20] zero[39:36]             |
//
// one byte is taken per cycle while the token queue has room for two tokens
// a byte yields zero, one or two tokens; the result port sends one token a cycle
// while out_tready is high, so the output stage paces a run of two-token bytes
// a byte's first token goes through the queue, then the output register
// rst_n is synchronous, active low, and rewinds the scan state and empties the queue
// a stall on the result side fills the queue and then drops in_tready
`timescale 1ns / 1ps

module expression_token_scanner import etsc_pkg::*; #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [CH_W-1:0]    in_tdata,   // ch
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // token_kind, token_offset, token_length
  output logic               out_tlast
);

  push_t push;
  logic  q_space;
  logic  q_valid;
  tok_t  q_head;
  logic  q_pop;

  // classify and scan
  etsc_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_ch     (in_tdata),
    .q_space   (q_space),
    .push      (push)
  );

  // token queue
  etsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_space (q_space),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // result stream
  etsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- design/etsc_front.sv -----
// etsc_front: byte classifier and scan state, produces up to two tokens per item
`timescale 1ns / 1ps

module etsc_front import etsc_pkg::*; #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [CH_W-1:0] in_ch,
  input  logic            q_space,
  output push_t           push
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_FRAC
  } mode_t;

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
  localparam int unsigned EXT_W = POS_WIDTH + OUT_W;

  mode_t                mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] start_r, start_nxt;

  logic  acc;
  logic  is_digit, is_letter, is_space, is_ident;
  logic  flush_v, fresh_v;
  tok_t  flush_tok, fresh_tok;
  kind_t op_kind;

  // saturate a position to the result field width
  function automatic logic [OUT_W-1:0] clip(input logic [POS_WIDTH-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (ext > EXT_W'(OUT_MAX)) return OUT_MAX;
    return ext[OUT_W-1:0];
  endfunction

  assign in_tready = q_space;
  assign acc       = in_tvalid && in_tready;

  // byte classes
  assign is_digit  = (in_ch >= CH_0) && (in_ch <= CH_9);
  assign is_letter = ((in_ch >= CH_LA) && (in_ch <= CH_LZ)) ||
                     ((in_ch >= CH_UA) && (in_ch <= CH_UZ));
  assign is_space  = (in_ch == CH_SPACE) || ((in_ch >= CH_TAB) && (in_ch <= CH_CR));
  assign is_ident  = is_letter || is_digit || (in_ch == CH_UNDER);

  // operator decoder
  always_comb begin
    unique case (in_ch)
      CH_PLUS:   op_kind = KIND_PLUS;
      CH_MINUS:  op_kind = KIND_MINUS;
      CH_STAR:   op_kind = KIND_STAR;
      CH_SLASH:  op_kind = KIND_SLASH;
      CH_PCT:    op_kind = KIND_PCT;
      CH_CARET:  op_kind = KIND_CARET;
      CH_EQ:     op_kind = KIND_EQ;
      CH_LPAREN: op_kind = KIND_LPAREN;
      CH_RPAREN: op_kind = KIND_RPAREN;
      CH_COMMA:  op_kind = KIND_COMMA;
      default:   op_kind = KIND_ERR;
    endcase
  end

  // scan step: flush of a pending token, then the byte taken on its own
  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    pos_nxt   = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
    flush_v   = 1'b0;
    fresh_v   = 1'b0;
    flush_tok.kind   = KIND_IDENT;
    flush_tok.offset = clip(start_r);
    flush_tok.length = clip(pos_r - start_r);
    flush_tok.last   = 1'b0;
    fresh_tok.kind   = op_kind;
    fresh_tok.offset = clip(pos_r);
    fresh_tok.length = (pos_r != POS_MAX) ? OUT_W'(1) : '0;
    fresh_tok.last   = 1'b1;

    unique case (mode_r)
      MODE_IDENT: begin
        if (!is_ident) begin
          flush_v  = 1'b1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_INT: begin
        if (in_ch == CH_DOT) begin
          mode_nxt = MODE_FRAC;
        end else if (!is_digit) begin
          flush_v        = 1'b1;
          flush_tok.kind = KIND_NUMBER;
          mode_nxt       = MODE_IDLE;
        end
      end
      MODE_FRAC: begin
        if (!is_digit) begin
          flush_v        = 1'b1;
          flush_tok.kind = KIND_NUMBER;
          mode_nxt       = MODE_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (mode_r == MODE_IDLE || flush_v) begin
      if (in_ch == CH_NUL) begin
        // end of text: eof token and rewind
        fresh_v          = 1'b1;
        fresh_tok.kind   = KIND_EOF;
        fresh_tok.length = '0;
        mode_nxt         = MODE_IDLE;
        pos_nxt          = '0;
        start_nxt        = '0;
      end else if (is_digit) begin
        mode_nxt  = MODE_INT;
        start_nxt = pos_r;
      end else if (is_letter || in_ch == CH_UNDER) begin
        mode_nxt  = MODE_IDENT;
        start_nxt = pos_r;
      end else if (!is_space) begin
        fresh_v   = 1'b1;
        start_nxt = pos_r;
      end
    end
  end

  // queue push: flushed token first, last flag on the final one
  always_comb begin
    push.cnt = acc ? ({1'b0, flush_v} + {1'b0, fresh_v}) : 2'd0;
    push.t0  = flush_v ? flush_tok : fresh_tok;
    push.t0.last = !(flush_v && fresh_v);
    push.t1  = fresh_tok;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// ----- design/etsc_queue.sv -----
// etsc_queue: small token queue, up to two pushes and one pop per cycle
`timescale 1ns / 1ps

module etsc_queue import etsc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  q_space,
  output logic  q_valid,
  output tok_t  q_head,
  input  logic  q_pop
);

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  // room for two tokens so a whole item always fits
  assign q_space = (count_r <= QCNT_W'(QDEPTH - 2));
  assign q_valid = (count_r != '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_pop  = q_pop && q_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
    count_nxt  = count_r + QCNT_W'(push.cnt) - QCNT_W'(do_pop);
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.t0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + 1'b1] <= push.t1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- design/etsc_back.sv -----
// etsc_back: output register that drains the token queue onto the result stream
`timescale 1ns / 1ps

module etsc_back import etsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tok_t               q_head,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tlast
);

  logic out_valid_r;
  tok_t out_tok_r;

  // load when the register is empty or being taken
  assign q_pop = q_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_tok_r <= q_head;
    end
  end

  // pack kind, offset, length from the low bits up
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'({out_tok_r.length, out_tok_r.offset, out_tok_r.kind});
  assign out_tlast  = out_tok_r.last;

endmodule

// ----- design/etsc_checker.sv -----
// etsc_checker: port-level assertions for the expression token scanner, bound to the top
`timescale 1ns / 1ps

module etsc_checker import etsc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic [CH_W-1:0]    in_tdata,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tlast
);

  logic [KIND_W-1:0] kind;
  logic [OUT_W-1:0]  length;

  assign kind   = out_tdata[KIND_W-1:0];
  assign length = out_tdata[KIND_W+2*OUT_W-1:KIND_W+OUT_W];

  // waiting input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input item changed while waiting");

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  // eof is empty and closes its run
  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && kind == KIND_EOF |-> length == '0 && out_tlast)
    else $error("eof token with length or without last");

  // single byte tokens are at most one byte long
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && kind != KIND_IDENT && kind != KIND_NUMBER |-> length <= OUT_W'(1))
    else $error("operator or error token longer than one byte");

  // padding above the packed fields stays zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TDATA_W-1:TDATA_BITS] == '0)
    else $error("padding bits of result item not zero");

endmodule

bind expression_token_scanner etsc_checker u_etsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
